### src/fcpq_pkg.sv
// Shared types and constants for the four-class priority queue with wait statistics.
// No dependencies.
package fcpq_pkg;

    localparam int DEF_QUEUE_DEPTH = 64;
    localparam int DEF_NUM_CLASSES = 4;

    localparam int OUT_CLASSES = 4;
    localparam int STAMP_W     = 11;
    localparam int WAIT_W      = 12;
    localparam int WAITING_W   = 7;
    localparam int COUNT_W     = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;
    localparam logic [STAMP_W-1:0] MINUTES_PER_HR = 11'd60;

    typedef enum logic [1:0] {
        OP_ARRIVE = 2'd0,
        OP_SERVE  = 2'd1,
        OP_REPORT = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_ADDED  = 3'd0,
        ST_SERVED = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_FULL   = 3'd3,
        ST_REPORT = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_POP  = 1'b1
    } t_state;

endpackage

### src/four_class_priority_queue_wait_stats.sv
// Top level: strict-priority queue of arrival stamps per class, with wait statistics.
// Depends on fcpq_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries op, class, hour and minute.
//   Output channel (o_out_valid / i_out_ready) returns one result per transaction.
//   An accepted transaction first lands in a request register, so the block takes a
//   new transaction while a finished result still waits in the output register.
//   Arrive, report and empty-serve pass from the request register straight into the
//   output register once it is free. A serve with a waiting item first reads the head
//   stamp from the arrival memory (synchronous read), then updates the pointers,
//   counters and maximum wait and registers the result.
//   Sustained rate: one transaction per cycle for arrive/report while i_out_ready stays
//   high; a serve holds its request until the pop completes, so the next one waits.
//   Reset clears occupancy, head pointers, served counts, maximum wait and both
//   handshake stages; the arrival memory is not cleared.
//   When the receiver stalls, the result holds in the output register; one more
//   transaction is buffered, then o_in_ready drops.
module four_class_priority_queue_wait_stats
    import fcpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int NUM_CLASSES = DEF_NUM_CLASSES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_op,
    input  logic [1:0]                  i_priority_class,
    input  logic [4:0]                  i_hour,
    input  logic [5:0]                  i_minute,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [2:0]                  o_status,
    output logic signed [WAIT_W-1:0]    o_wait_minutes,
    output logic [1:0]                  o_served_class,
    output logic [WAITING_W-1:0]        o_waiting_emergency,
    output logic [WAITING_W-1:0]        o_waiting_urgent,
    output logic [WAITING_W-1:0]        o_waiting_less_urgent,
    output logic [WAITING_W-1:0]        o_waiting_non_urgent,
    output logic [COUNT_W-1:0]          o_served_emergency,
    output logic [COUNT_W-1:0]          o_served_urgent,
    output logic [COUNT_W-1:0]          o_served_less_urgent,
    output logic [COUNT_W-1:0]          o_served_non_urgent,
    output logic [STAMP_W-1:0]          o_max_wait
);

    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CI_W        = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int STORE_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // request register
    logic               r_req_valid, n_req_valid;
    t_op                r_op;
    logic [1:0]         r_cls;
    logic [4:0]         r_hour;
    logic [5:0]         r_minute;

    // queue state
    t_state             r_state, n_state;
    logic [PTR_W-1:0]   r_head [NUM_CLASSES];
    logic [PTR_W-1:0]   n_head [NUM_CLASSES];
    logic [OCC_W-1:0]   r_occ  [NUM_CLASSES];
    logic [OCC_W-1:0]   n_occ  [NUM_CLASSES];
    logic [COUNT_W-1:0] r_cnt  [NUM_CLASSES];
    logic [COUNT_W-1:0] n_cnt  [NUM_CLASSES];
    logic [STAMP_W-1:0] r_max, n_max;
    logic [CI_W-1:0]    r_pop_cls, n_pop_cls;

    // arrival memory
    logic [STAMP_W-1:0] r_store [STORE_DEPTH];
    logic [STAMP_W-1:0] r_rdata;
    logic               mem_we, mem_re;
    logic [ADDR_W-1:0]  mem_addr;

    // output register
    logic                       r_out_valid, n_out_valid;
    t_status                    r_status, n_status;
    logic signed [WAIT_W-1:0]   r_wait, n_wait;
    logic [1:0]                 r_srv_cls, n_srv_cls;
    logic [WAITING_W-1:0]       r_wtg [OUT_CLASSES];
    logic [WAITING_W-1:0]       n_wtg [OUT_CLASSES];
    logic [COUNT_W-1:0]         r_scnt [OUT_CLASSES];
    logic [COUNT_W-1:0]         n_scnt [OUT_CLASSES];
    logic [STAMP_W-1:0]         r_omax, n_omax;

    logic               out_free, req_done, load_out, any_waiting;
    logic [CI_W-1:0]    cls_sel, found;
    logic [STAMP_W-1:0] stamp;
    logic [PTR_W:0]     slot_sum;
    logic [PTR_W-1:0]   slot;
    logic signed [WAIT_W-1:0] pop_wait;

    assign stamp = 11'({6'd0, r_hour} * MINUTES_PER_HR) + {5'd0, r_minute};
    assign out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_req_valid || req_done;

    always_comb begin
        if (int'(r_cls) >= NUM_CLASSES) begin
            cls_sel = CI_W'(NUM_CLASSES - 1);
        end else begin
            cls_sel = CI_W'(r_cls);
        end
        found = '0;
        any_waiting = 1'b0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (r_occ[c] != '0) begin
                found = CI_W'(c);
                any_waiting = 1'b1;
            end
        end
        slot_sum = {1'b0, r_head[cls_sel]} + (PTR_W + 1)'(r_occ[cls_sel]);
        if (slot_sum >= (PTR_W + 1)'(QUEUE_DEPTH)) begin
            slot = PTR_W'(slot_sum - (PTR_W + 1)'(QUEUE_DEPTH));
        end else begin
            slot = PTR_W'(slot_sum);
        end
        pop_wait = $signed({1'b0, stamp}) - $signed({1'b0, r_rdata});
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_occ       = r_occ;
        n_cnt       = r_cnt;
        n_max       = r_max;
        n_pop_cls   = r_pop_cls;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_wait      = r_wait;
        n_srv_cls   = r_srv_cls;
        n_wtg       = r_wtg;
        n_scnt      = r_scnt;
        n_omax      = r_omax;
        req_done    = 1'b0;
        load_out    = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = ADDR_W'(cls_sel) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);

        case (r_state)
            S_IDLE: begin
                if (r_req_valid && out_free) begin
                    n_wait    = '0;
                    n_srv_cls = '0;
                    case (r_op)
                        OP_ARRIVE: begin
                            load_out = 1'b1;
                            if (r_occ[cls_sel] == OCC_W'(QUEUE_DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_we = 1'b1;
                                n_occ[cls_sel] = r_occ[cls_sel] + 1'b1;
                                n_status = ST_ADDED;
                            end
                        end
                        OP_SERVE: begin
                            if (!any_waiting) begin
                                load_out = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                mem_re    = 1'b1;
                                mem_addr  = ADDR_W'(found) * ADDR_W'(QUEUE_DEPTH)
                                          + ADDR_W'(r_head[found]);
                                n_pop_cls = found;
                                n_state   = S_POP;
                            end
                        end
                        default: begin
                            load_out = 1'b1;
                            n_status = ST_REPORT;
                        end
                    endcase
                end
            end
            S_POP: begin
                load_out  = 1'b1;
                n_status  = ST_SERVED;
                n_wait    = pop_wait;
                n_srv_cls = 2'(r_pop_cls);
                if (pop_wait > $signed({1'b0, r_max})) begin
                    n_max = pop_wait[STAMP_W-1:0];
                end
                if (r_head[r_pop_cls] == PTR_W'(QUEUE_DEPTH - 1)) begin
                    n_head[r_pop_cls] = '0;
                end else begin
                    n_head[r_pop_cls] = r_head[r_pop_cls] + 1'b1;
                end
                n_occ[r_pop_cls] = r_occ[r_pop_cls] - 1'b1;
                if (r_cnt[r_pop_cls] != COUNT_MAX) begin
                    n_cnt[r_pop_cls] = r_cnt[r_pop_cls] + 1'b1;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (load_out) begin
            req_done    = 1'b1;
            n_out_valid = 1'b1;
            n_omax      = n_max;
            for (int c = 0; c < OUT_CLASSES; c++) begin
                if (c < NUM_CLASSES) begin
                    n_wtg[c]  = WAITING_W'(n_occ[CI_W'(c)]);
                    n_scnt[c] = n_cnt[CI_W'(c)];
                end else begin
                    n_wtg[c]  = '0;
                    n_scnt[c] = '0;
                end
            end
        end

        n_req_valid = r_req_valid && !req_done;
        if (i_in_valid && o_in_ready) begin
            n_req_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_req_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_max       <= '0;
            r_pop_cls   <= '0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_head[c] <= '0;
                r_occ[c]  <= '0;
                r_cnt[c]  <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_req_valid <= n_req_valid;
            r_out_valid <= n_out_valid;
            r_max       <= n_max;
            r_pop_cls   <= n_pop_cls;
            r_head      <= n_head;
            r_occ       <= n_occ;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_op     <= t_op'(i_op);
            r_cls    <= i_priority_class;
            r_hour   <= i_hour;
            r_minute <= i_minute;
        end
        r_status  <= n_status;
        r_wait    <= n_wait;
        r_srv_cls <= n_srv_cls;
        r_wtg     <= n_wtg;
        r_scnt    <= n_scnt;
        r_omax    <= n_omax;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_addr] <= stamp;
        end
        if (mem_re) begin
            r_rdata <= r_store[mem_addr];
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_status              = r_status;
    assign o_wait_minutes        = r_wait;
    assign o_served_class        = r_srv_cls;
    assign o_waiting_emergency   = r_wtg[0];
    assign o_waiting_urgent      = r_wtg[1];
    assign o_waiting_less_urgent = r_wtg[2];
    assign o_waiting_non_urgent  = r_wtg[3];
    assign o_served_emergency    = r_scnt[0];
    assign o_served_urgent       = r_scnt[1];
    assign o_served_less_urgent  = r_scnt[2];
    assign o_served_non_urgent   = r_scnt[3];
    assign o_max_wait            = r_omax;

    // a pop is only started on a class with a live item
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_POP |-> r_occ[r_pop_cls] != '0)
        else $error("pop started on empty class");

    // the pop state is never held: idle always follows it
    a_pop_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_POP |=> r_state == S_IDLE)
        else $error("pop state held");

    // maximum wait never falls
    a_max_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_max >= $past(r_max))
        else $error("maximum wait decreased");

    // non-serve results carry zero wait and class
    a_nonserve_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status != ST_SERVED |-> r_wait == '0 && r_srv_cls == '0)
        else $error("wait or class set on non-serve result");

    // occupancy of class zero bounded by the queue depth
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ[0] <= OCC_W'(QUEUE_DEPTH))
        else $error("occupancy beyond depth");

endmodule
